### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

### sv/spnt_pkg.sv
// Package with types, constants and helper functions of the spectral peak note tuner.
`timescale 1ns / 1ps
package spnt_pkg;

    localparam int SPNT_BIN_COUNT = 16384;

    localparam logic [23:0] HZ_RESET  = 24'd95996;
    localparam logic [27:0] REF_RESET = 28'd28835840;

    localparam logic [0:0] REG_HZ_PER_BIN = 1'b0;
    localparam logic [0:0] REG_REFERENCE  = 1'b1;

    localparam int LOG_W = 22;
    localparam int NUM_W = 39;
    localparam int DEN_W = 27;

    localparam logic [2:0] LSEL_PEAK  = 3'd0;
    localparam logic [2:0] LSEL_LEFT  = 3'd1;
    localparam logic [2:0] LSEL_RIGHT = 3'd2;
    localparam logic [2:0] LSEL_FREQ  = 3'd3;
    localparam logic [2:0] LSEL_REF   = 3'd4;

    typedef struct packed {
        logic       in_ready;
        logic       clr_delta;
        logic       log_start;
        logic [2:0] log_sel;
        logic       div_start;
        logic       mul;
        logic       fin1;
        logic       fin2;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic frame_end;
        logic interp_ok;
        logic den_pos;
        logic log_done;
        logic div_done;
        logic freq_pos;
        logic out_free;
    } t_stat;

    // Remainder modulo 12 of a value below 1536, by restoring subtraction.
    function automatic logic [3:0] spnt_mod12(input logic [10:0] u);
        logic [10:0] v;
        v = u;
        for (int k = 6; k >= 0; k--) begin
            if (v >= 11'(12 << k)) begin
                v = v - 11'(12 << k);
            end
        end
        return v[3:0];
    endfunction

endpackage

### sv/spnt_log2.sv
// Serial base-2 logarithm in Q.16: normalize in six steps, then sixteen squarings.
`timescale 1ns / 1ps
module spnt_log2 import spnt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [63:0]      i_x,
    output logic             o_done,
    output logic [LOG_W-1:0] o_res
);
    logic        r_busy;
    logic [4:0]  r_step;
    logic [63:0] r_x;
    logic [5:0]  r_sh;
    logic [31:0] r_m;
    logic [15:0] r_frac;
    logic        r_done;

    logic [5:0]  w_s;
    logic [63:0] w_mask;
    logic        w_zero;
    logic [63:0] n_x;
    logic [5:0]  n_sh;
    logic [63:0] w_sq;
    logic [32:0] w_t;

    assign w_s    = 6'(32 >> r_step);
    assign w_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> w_s);
    assign w_zero = (r_x & w_mask) == 64'd0;
    assign n_x    = w_zero ? (r_x << w_s) : r_x;
    assign n_sh   = w_zero ? (r_sh + w_s) : r_sh;
    assign w_sq   = r_m * r_m;
    assign w_t    = w_sq[63:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_step == 5'd21);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_x    <= i_x;
                r_sh   <= '0;
                r_frac <= '0;
            end else if (r_busy) begin
                if (r_step < 5'd6) begin
                    r_x  <= n_x;
                    r_sh <= n_sh;
                    if (r_step == 5'd5) begin
                        r_m <= n_x[63:32];
                    end
                end else begin
                    if (w_t[32]) begin
                        r_m <= w_t[32:1];
                    end else begin
                        r_m <= w_t[31:0];
                    end
                    r_frac <= {r_frac[14:0], w_t[32]};
                end
                if (r_step == 5'd21) begin
                    r_busy <= 1'b0;
                end
                r_step <= r_step + 5'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = {6'd63 - r_sh, r_frac};
endmodule

### sv/spnt_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module spnt_div import spnt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_q
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_k;
    logic [NUM_W-1:0] r_a;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_d;
    logic [DEN_W-1:0] r_rem;
    logic             r_neg;

    logic [DEN_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_a[NUM_W-1]};
    assign w_ge = w_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_k == CW'(NUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_a    <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
                r_neg  <= i_num[NUM_W-1];
                r_d    <= DEN_W'(i_den);
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_a   <= r_a << 1;
                r_q   <= {r_q[NUM_W-2:0], w_ge};
                r_rem <= w_ge ? DEN_W'(w_sh - {1'b0, r_d}) : DEN_W'(w_sh);
                if (r_k == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
                r_k <= r_k + CW'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

### sv/spnt_datapath.sv
// Datapath: peak tracking, configuration, log and divide units, pitch math, output register.
`timescale 1ns / 1ps
module spnt_datapath import spnt_pkg::*; #(
    parameter int BIN_COUNT = SPNT_BIN_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_in_valid,
    input  logic [31:0]        i_bin_magnitude,
    input  logic               i_last_bin,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [27:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_note_class,
    output logic signed [7:0]  o_semitone_steps,
    output logic signed [6:0]  o_cents_offset,
    output logic [13:0]        o_peak_bin,
    output logic               o_pitch_valid
);
    localparam int IW = $clog2(BIN_COUNT);
    localparam int PW = IW + 18;
    localparam int FW = PW + 25;

    logic [31:0]    r_best, r_left, r_right, r_prev;
    logic [IW-1:0]  r_bidx, r_cnt;
    logic           r_await;
    logic [31:0]    n_best, n_left, n_right;
    logic [IW-1:0]  n_bidx, n_cnt;
    logic           n_await;
    logic [23:0]    r_hz;
    logic [27:0]    r_ref;
    logic [LOG_W-1:0] r_lp, r_ll, r_lr, r_lf, r_lref;
    logic signed [16:0]  r_delta;
    logic signed [FW-1:0] r_freq;
    logic signed [27:0]  r_steps;
    logic signed [11:0]  r_n;
    logic [3:0]          r_cls;
    logic signed [7:0]   r_semi;
    logic signed [6:0]   r_cents;
    logic                r_pv;
    logic                r_o_valid;
    logic [3:0]          r_o_cls;
    logic signed [7:0]   r_o_semi;
    logic signed [6:0]   r_o_cents;
    logic [13:0]         r_o_bin;
    logic                r_o_pv;

    logic                 w_accept;
    logic [63:0]          w_log_x;
    logic                 w_log_done;
    logic [LOG_W-1:0]     w_log_res;
    logic signed [DEN_W-1:0] w_den;
    logic signed [NUM_W-1:0] w_num;
    logic                 w_div_done;
    logic signed [NUM_W-1:0] w_q;
    logic signed [PW-1:0] w_pos;
    logic signed [23:0]   w_diff;
    logic signed [27:0]   w_steps;
    logic signed [28:0]   w_sv;
    logic signed [11:0]   w_n;
    logic signed [29:0]   w_rem;
    logic signed [31:0]   w_r100;
    logic signed [6:0]    w_c;
    logic [10:0]          w_u;
    logic [31:0]          w_bidx32;
    logic                 w_fpos;

    assign w_accept = i_in_valid && i_cmd.in_ready;

    always_comb begin
        n_best  = r_best;
        n_bidx  = r_bidx;
        n_left  = r_left;
        n_right = r_right;
        n_await = r_await;
        n_cnt   = r_cnt;
        if (r_await) begin
            n_right = i_bin_magnitude;
            n_await = 1'b0;
        end
        if (r_cnt == '0 || i_bin_magnitude > r_best) begin
            n_best  = i_bin_magnitude;
            n_bidx  = r_cnt;
            n_left  = (r_cnt == '0) ? 32'd0 : r_prev;
            n_right = 32'd0;
            n_await = 1'b1;
        end
        if (r_cnt < IW'(BIN_COUNT - 1)) begin
            n_cnt = r_cnt + IW'(1);
        end
    end

    always_comb begin
        unique case (i_cmd.log_sel)
            LSEL_PEAK:  w_log_x = 64'(r_best);
            LSEL_LEFT:  w_log_x = 64'(r_left);
            LSEL_RIGHT: w_log_x = 64'(r_right);
            LSEL_FREQ:  w_log_x = 64'(unsigned'(r_freq));
            default:    w_log_x = (r_ref == 28'd0) ? 64'd1 : 64'(r_ref);
        endcase
    end

    spnt_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.log_start),
        .i_x     (w_log_x),
        .o_done  (w_log_done),
        .o_res   (w_log_res)
    );

    assign w_den = ((($signed({5'b0, r_lp})) <<< 1) - $signed({5'b0, r_ll})
                   - $signed({5'b0, r_lr})) <<< 1;
    assign w_num = ($signed({17'b0, r_lr}) - $signed({17'b0, r_ll})) <<< 16;

    spnt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    assign w_pos   = $signed({2'b0, r_bidx, 16'b0}) + PW'(r_delta);
    assign w_fpos  = !r_freq[FW-1] && (r_freq != '0);
    assign w_diff  = $signed({2'b0, r_lf}) - $signed({2'b0, r_lref}) - 24'sd1048576;
    assign w_steps = (28'(w_diff) <<< 3) + (28'(w_diff) <<< 2);
    assign w_sv    = 29'(w_steps);
    assign w_n     = w_sv[28] ? 12'(-((-w_sv + 29'sd32768) >>> 16))
                              : 12'((w_sv + 29'sd32768) >>> 16);
    assign w_rem   = 30'(r_steps) - (30'(r_n) <<< 16);
    assign w_r100  = 32'(w_rem) * 32'sd100;
    assign w_c     = w_r100[31] ? 7'(-((-w_r100 + 32'sd32768) >>> 16))
                                : 7'((w_r100 + 32'sd32768) >>> 16);
    assign w_u     = 11'(r_n + 12'sd768);
    assign w_bidx32 = 32'(r_bidx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best    <= '0;
            r_bidx    <= '0;
            r_left    <= '0;
            r_right   <= '0;
            r_prev    <= '0;
            r_cnt     <= '0;
            r_await   <= 1'b0;
            r_hz      <= HZ_RESET;
            r_ref     <= REF_RESET;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_HZ_PER_BIN: r_hz  <= i_cfg_data[23:0];
                    REG_REFERENCE:  r_ref <= i_cfg_data;
                    default:        r_ref <= r_ref;
                endcase
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
                r_best    <= '0;
                r_bidx    <= '0;
                r_left    <= '0;
                r_right   <= '0;
                r_prev    <= '0;
                r_cnt     <= '0;
                r_await   <= 1'b0;
            end else begin
                if (w_accept) begin
                    r_best  <= n_best;
                    r_bidx  <= n_bidx;
                    r_left  <= n_left;
                    r_right <= n_right;
                    r_await <= n_await;
                    r_cnt   <= n_cnt;
                    r_prev  <= i_bin_magnitude;
                end
                if (r_o_valid && i_out_ready) begin
                    r_o_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_log_done) begin
            unique case (i_cmd.log_sel)
                LSEL_PEAK:  r_lp   <= w_log_res;
                LSEL_LEFT:  r_ll   <= w_log_res;
                LSEL_RIGHT: r_lr   <= w_log_res;
                LSEL_FREQ:  r_lf   <= w_log_res;
                default:    r_lref <= w_log_res;
            endcase
        end
        if (i_cmd.clr_delta) begin
            r_delta <= '0;
        end else if (w_div_done) begin
            r_delta <= 17'(w_q);
        end
        if (i_cmd.mul) begin
            r_freq <= FW'(w_pos) * $signed({1'b0, r_hz});
        end
        if (i_cmd.fin1) begin
            r_steps <= w_steps;
            r_n     <= w_n;
        end
        if (i_cmd.fin2) begin
            if (w_fpos) begin
                r_cls   <= spnt_mod12(w_u);
                r_cents <= w_c;
                r_pv    <= 1'b1;
                if (r_n > 12'sd127) begin
                    r_semi <= 8'sd127;
                end else if (r_n < -12'sd128) begin
                    r_semi <= -8'sd128;
                end else begin
                    r_semi <= 8'(r_n);
                end
            end else begin
                r_cls   <= '0;
                r_cents <= '0;
                r_semi  <= '0;
                r_pv    <= 1'b0;
            end
        end
        if (i_cmd.load_out) begin
            r_o_cls   <= r_cls;
            r_o_semi  <= r_semi;
            r_o_cents <= r_cents;
            r_o_bin   <= w_bidx32[13:0];
            r_o_pv    <= r_pv;
        end
    end

    assign o_stat.frame_end = i_in_valid && i_last_bin;
    assign o_stat.interp_ok = (r_bidx != '0) && !r_await && (r_left != 32'd0)
                              && (r_right != 32'd0);
    assign o_stat.den_pos   = !w_den[DEN_W-1] && (w_den != '0);
    assign o_stat.log_done  = w_log_done;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.freq_pos  = w_fpos;
    assign o_stat.out_free  = !r_o_valid || i_out_ready;

    assign o_out_valid      = r_o_valid;
    assign o_note_class     = r_o_cls;
    assign o_semitone_steps = r_o_semi;
    assign o_cents_offset   = r_o_cents;
    assign o_peak_bin       = r_o_bin;
    assign o_pitch_valid    = r_o_pv;
endmodule

### sv/spnt_ctrl.sv
// Controller state machine that sequences the end-of-frame pitch computation.
`timescale 1ns / 1ps
module spnt_ctrl import spnt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [3:0] ST_RUN  = 4'd0;
    localparam logic [3:0] ST_CHK  = 4'd1;
    localparam logic [3:0] ST_LP   = 4'd2;
    localparam logic [3:0] ST_LL   = 4'd3;
    localparam logic [3:0] ST_LR   = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_MUL  = 4'd6;
    localparam logic [3:0] ST_CHKF = 4'd7;
    localparam logic [3:0] ST_LF   = 4'd8;
    localparam logic [3:0] ST_LREF = 4'd9;
    localparam logic [3:0] ST_FIN1 = 4'd10;
    localparam logic [3:0] ST_FIN2 = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_issued, n_issued;

    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        o_cmd    = '0;
        o_cmd.log_sel = LSEL_PEAK;
        unique case (r_state)
            ST_RUN: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.frame_end) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                o_cmd.clr_delta = 1'b1;
                n_state = i_stat.interp_ok ? ST_LP : ST_MUL;
            end
            ST_LP, ST_LL, ST_LR, ST_LF, ST_LREF: begin
                unique case (r_state)
                    ST_LP:   o_cmd.log_sel = LSEL_PEAK;
                    ST_LL:   o_cmd.log_sel = LSEL_LEFT;
                    ST_LR:   o_cmd.log_sel = LSEL_RIGHT;
                    ST_LF:   o_cmd.log_sel = LSEL_FREQ;
                    default: o_cmd.log_sel = LSEL_REF;
                endcase
                o_cmd.log_start = !r_issued;
                n_issued = 1'b1;
                if (i_stat.log_done) begin
                    n_issued = 1'b0;
                    unique case (r_state)
                        ST_LP:   n_state = ST_LL;
                        ST_LL:   n_state = ST_LR;
                        ST_LR:   n_state = ST_DIV;
                        ST_LF:   n_state = ST_LREF;
                        default: n_state = ST_FIN1;
                    endcase
                end
            end
            ST_DIV: begin
                if (!i_stat.den_pos) begin
                    n_state = ST_MUL;
                end else begin
                    o_cmd.div_start = !r_issued;
                    n_issued = 1'b1;
                    if (i_stat.div_done) begin
                        n_issued = 1'b0;
                        n_state  = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_CHKF;
            end
            ST_CHKF: begin
                n_state = i_stat.freq_pos ? ST_LF : ST_FIN2;
            end
            ST_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state    = ST_FIN2;
            end
            ST_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_RUN;
                end
            end
            default: begin
                n_state  = ST_RUN;
                n_issued = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RUN;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end
endmodule

### sv/spectral_peak_note_tuner.sv
// Top level of the spectral peak note tuner: controller and datapath.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  bins    | i_in_valid, o_in_ready, i_bin_magnitude,  | in
//          | i_last_bin                                |
//  notes   | o_out_valid, i_out_ready, o_note_class,   | out
//          | o_semitone_steps, o_cents_offset,         |
//          | o_peak_bin, o_pitch_valid                 |
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data           | in
//
// Bins are taken one per cycle while a frame streams in.
// After the last bin is taken, the result takes at most five passes through the shared
// log2 unit, the serial divider and six single steps; without interpolation, the divider
// and three log passes are skipped, and with a zero frequency the other two passes too.
// No bin is taken during that work, nor while a new result waits for the output register.
// Reset is synchronous, active low, clears the frame state and sets registers to defaults.
`timescale 1ns / 1ps
module spectral_peak_note_tuner import spnt_pkg::*; #(
    parameter int BIN_COUNT = SPNT_BIN_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [31:0]       i_bin_magnitude,
    input  logic              i_last_bin,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [3:0]        o_note_class,
    output logic signed [7:0] o_semitone_steps,
    output logic signed [6:0] o_cents_offset,
    output logic [13:0]       o_peak_bin,
    output logic              o_pitch_valid,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [27:0]       i_cfg_data
);
    t_cmd  w_cmd;
    t_stat w_stat;

    spnt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    spnt_datapath #(
        .BIN_COUNT (BIN_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_in_valid       (i_in_valid),
        .i_bin_magnitude  (i_bin_magnitude),
        .i_last_bin       (i_last_bin),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_note_class     (o_note_class),
        .o_semitone_steps (o_semitone_steps),
        .o_cents_offset   (o_cents_offset),
        .o_peak_bin       (o_peak_bin),
        .o_pitch_valid    (o_pitch_valid)
    );

    assign o_in_ready = w_cmd.in_ready;
endmodule

### sv/spnt_checker.sv
// Port-level checker for the spectral peak note tuner, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spnt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              i_last_bin,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [3:0]        o_note_class,
    input logic signed [7:0] o_semitone_steps,
    input logic signed [6:0] o_cents_offset,
    input logic              o_pitch_valid
);
    logic w_fields_zero;
    logic w_cents_ok;

    assign w_fields_zero = (o_note_class == 4'd0) && (o_semitone_steps == 8'sd0)
                           && (o_cents_offset == 7'sd0);
    assign w_cents_ok    = (o_cents_offset <= 7'sd50) && (o_cents_offset >= -7'sd50);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_IMPLY(a_invalid_zero, i_clk, i_rst_n, o_out_valid && !o_pitch_valid, w_fields_zero)
    `ASSERT_IMPLY(a_class_range, i_clk, i_rst_n, o_out_valid, o_note_class < 4'd12)
    `ASSERT_IMPLY(a_cents_range, i_clk, i_rst_n, o_out_valid, w_cents_ok)
    `ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, i_in_valid && o_in_ready && i_last_bin, !o_in_ready)
endmodule

bind spectral_peak_note_tuner spnt_checker u_spnt_checker (.*);

### tb/spectral_peak_note_tuner_tb.sv
// Testbench for the spectral peak note tuner: spectrum frames checked against a bit-true predictor.
`timescale 1ns / 1ps
module spectral_peak_note_tuner_tb;
    import spnt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 250;
    localparam int HOLD_CYCLES    = 700;

    typedef struct {
        logic [3:0]  note;
        logic [7:0]  semi;
        logic [6:0]  cents;
        logic [13:0] peak;
        logic        valid;
    } note_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_bin_magnitude;
    logic        i_last_bin;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_note_class;
    logic signed [7:0] o_semitone_steps;
    logic signed [6:0] o_cents_offset;
    logic [13:0] o_peak_bin;
    logic        o_pitch_valid;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [27:0] i_cfg_data;

    spectral_peak_note_tuner uut (.*);

    note_t pending_notes[$];
    int    mismatches;
    int    quiet_cycles;
    bit    no_idle;
    int    hold_reqs;
    int    hold_done;
    int    hold_cnt;

    logic [23:0] hz_per_bin;
    logic [27:0] ref_hz;
    logic [31:0] peak_mag;
    logic [13:0] peak_idx;
    logic [31:0] left_mag;
    logic [31:0] right_mag;
    logic [31:0] prev_mag;
    logic [13:0] bin_idx;
    bit          want_right;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint log2_fix(input logic [63:0] x);
        int          top;
        logic [63:0] m;
        longint      frac;
        top = 0;
        frac = 0;
        if (x == 0) return 0;
        while (top < 63 && (x >> (top + 1)) != 0) top++;
        if (top >= 31) m = x >> (top - 31);
        else m = x << (31 - top);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | (longint'(1) << (15 - i));
                m = m >> 1;
            end
        end
        return longint'(top) * 65536 + frac;
    endfunction

    function automatic longint round_q16(input longint v);
        if (v >= 0) return (v + 32768) / 65536;
        return -((-v + 32768) / 65536);
    endfunction

    task automatic clear_frame();
        peak_mag = 0;
        peak_idx = 0;
        left_mag = 0;
        right_mag = 0;
        prev_mag = 0;
        bin_idx = 0;
        want_right = 0;
    endtask

    task automatic predict_bin(input logic [31:0] mag, input logic last);
        logic [13:0] idx;
        longint      delta, pos, freq, lp, ll, lr, den, diff, steps, n, rem, c, cls;
        note_t       r;
        idx = bin_idx;
        delta = 0;
        if (want_right) begin
            right_mag = mag;
            want_right = 0;
        end
        if (idx == 0 || mag > peak_mag) begin
            peak_mag = mag;
            peak_idx = idx;
            left_mag = (idx == 0) ? 32'd0 : prev_mag;
            right_mag = 0;
            want_right = 1;
        end
        prev_mag = mag;
        if (bin_idx < SPNT_BIN_COUNT - 1) bin_idx++;
        if (!last) return;
        if (peak_idx != 0 && !want_right && left_mag != 0 && right_mag != 0) begin
            lp = log2_fix(64'(peak_mag));
            ll = log2_fix(64'(left_mag));
            lr = log2_fix(64'(right_mag));
            den = 2 * (2 * lp - ll - lr);
            if (den > 0) delta = ((lr - ll) * 65536) / den;
        end
        pos = longint'(peak_idx) * 65536 + delta;
        freq = pos * longint'(hz_per_bin);
        r = '{note: 0, semi: 0, cents: 0, peak: peak_idx, valid: 0};
        if (freq > 0) begin
            diff = log2_fix(freq) - log2_fix(64'((ref_hz != 0) ? ref_hz : 28'd1))
                   - 16 * 65536;
            steps = 12 * diff;
            n = round_q16(steps);
            rem = steps - n * 65536;
            c = round_q16(rem * 100);
            cls = n % 12;
            if (cls < 0) cls += 12;
            if (n > 127) n = 127;
            if (n < -128) n = -128;
            r.note = cls[3:0];
            r.semi = n[7:0];
            r.cents = c[6:0];
            r.valid = 1;
        end
        pending_notes.push_back(r);
        clear_frame();
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Result checker and receiver stall control.
    always @(posedge i_clk) begin
        note_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_notes.size() == 0) begin
                report("unexpected result", o_peak_bin, -1);
            end else begin
                e = pending_notes.pop_front();
                if (o_note_class !== e.note) report("note_class", o_note_class, e.note);
                if (o_semitone_steps !== e.semi)
                    report("semitone_steps", o_semitone_steps, $signed(e.semi));
                if (o_cents_offset !== e.cents)
                    report("cents_offset", o_cents_offset, $signed(e.cents));
                if (o_peak_bin !== e.peak) report("peak_bin", o_peak_bin, e.peak);
                if (o_pitch_valid !== e.valid) report("pitch_valid", o_pitch_valid, e.valid);
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (hold_done != hold_reqs) begin
            hold_done <= hold_done + 1;
            hold_cnt <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_bin(input logic [31:0] mag, input logic last);
        while (!no_idle && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_bin_magnitude <= mag;
        i_last_bin <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_bin(mag, last);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_notes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [27:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_HZ_PER_BIN) hz_per_bin = data[23:0];
        else ref_hz = data;
    endtask

    function automatic logic [31:0] random_mag();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return $urandom_range(15);
            2: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom();
        endcase
    endfunction

    // A frame with a clear peak somewhere inside, sometimes raw noise.
    task automatic send_frame(input int len);
        int          top;
        logic [31:0] big;
        bit          shaped;
        top = $urandom_range(len - 1);
        big = $urandom() | 32'h8000_0000;
        shaped = $urandom_range(3) != 0;
        for (int k = 0; k < len; k++) begin
            if (shaped && k == top) send_bin(big, k == len - 1);
            else if (shaped && (k == top - 1 || k == top + 1))
                send_bin($urandom_range(1) ? (big >> $urandom_range(1, 20)) : random_mag() >> 1,
                         k == len - 1);
            else if (shaped) send_bin($urandom() >> $urandom_range(2, 31), k == len - 1);
            else send_bin(random_mag(), k == len - 1);
        end
    endtask

    task automatic test_special_frames();
        send_bin(32'd0, 1'b1);
        send_bin(32'd100, 1'b0);
        send_bin(32'd5000, 1'b0);
        send_bin(32'd300, 1'b1);
        send_bin(32'd10, 1'b0);
        send_bin(32'd20, 1'b0);
        send_bin(32'hFFFF_FFFF, 1'b1);
        send_bin(32'd0, 1'b0);
        send_bin(32'd500, 1'b0);
        send_bin(32'd200, 1'b1);
        send_bin(32'd3, 1'b0);
        send_bin(32'd8, 1'b0);
        send_bin(32'd8, 1'b1);
        send_bin(32'hFFFF_FFFE, 1'b0);
        send_bin(32'hFFFF_FFFF, 1'b0);
        send_bin(32'hFFFF_FFFF, 1'b1);
        send_bin(32'd1, 1'b0);
        send_bin(32'h5555_5555, 1'b0);
        send_bin(32'hAAAA_AAAA, 1'b0);
        send_bin(32'd1, 1'b1);
    endtask

    task automatic test_register_settings();
        logic [27:0] hz_set[5];
        logic [27:0] ref_set[5];
        hz_set = '{28'd1, 28'hFF_FFFF, 28'd95996, 28'd3000, 28'h12_3456};
        ref_set = '{28'd65536, 28'hFFF_FFFF, 28'd0, 28'd28835840, 28'h0AB_CDEF};
        for (int s = 0; s < 5; s++) begin
            write_reg(REG_HZ_PER_BIN, hz_set[s]);
            write_reg(REG_REFERENCE, ref_set[s]);
            repeat (4) send_frame($urandom_range(2, 9));
        end
        write_reg(REG_HZ_PER_BIN, 28'd95996);
        write_reg(REG_REFERENCE, 28'd28835840);
    endtask

    task automatic test_output_stall();
        hold_reqs++;
        repeat (6) send_frame($urandom_range(2, 6));
    endtask

    task automatic test_pause_until_done();
        send_frame(5);
        drain();
        send_frame(4);
    endtask

    task automatic test_random_frames();
        int sent;
        sent = 0;
        while (sent < 600) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            no_idle = (sent >= 250 && sent < 350);
            send_frame(len);
            sent += len;
        end
        no_idle = 0;
    endtask

    initial begin
        no_idle = 0;
        hold_reqs = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_bin_magnitude = '0;
        i_last_bin = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        hz_per_bin = HZ_RESET;
        ref_hz = REF_RESET;
        clear_frame();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_frames();
        test_register_settings();
        test_output_stall();
        test_pause_until_done();
        test_random_frames();
        drain();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
